// ----- src/tafs_pkg.sv -----
// Package for the triangle angle block: shared constants, fixed-point format
// and pipeline latencies. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tafs_pkg;

  // Defaults for the top-level parameters
  localparam int SIDE_BITS_DEF       = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 14;

  // Internal fixed point: cosine ratio and thresholds carry 28 fraction bits
  localparam int FX           = 28;
  // Taylor terms of cos(h), up to h^24/24!
  localparam int HORNER_TERMS = 12;
  // Reciprocal scaling for division of a Horner product by 2n(2n-1)
  localparam int RCP_SHIFT    = 32;
  localparam int RCP_BITS     = 33;
  // 2n(2n-1) for n = 12 stays below 2^10
  localparam int DIV_BITS     = 10;

  // pi with 61 fraction bits
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  // Ratio unit: products, difference, one stage per quotient bit, rounding
  localparam int RATIO_LAT = FX + 3;
  // One search step: half angle, square, three stages per term, square, update
  localparam int STEP_LAT  = 3 * HORNER_TERMS + 4;

  // Largest angle code: round(pi * 2^f)
  function automatic logic [63:0] ymax_of(input int f);
    return (PI_Q61 + (64'd1 << (60 - f))) >> (61 - f);
  endfunction

  // Binary search steps needed to cover [0, ymax]
  function automatic int search_steps(input int f);
    return $clog2(ymax_of(f) + 64'd1);
  endfunction

  // Width rounded up to whole bytes
  function automatic int bytes_up(input int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage
`default_nettype wire

// ----- src/tafs_ratio.sv -----
// Cosine ratio unit: (p^2 + q^2 - m^2) / (2pq) as signed Q.28, rounded.
// Restoring division, one quotient bit per pipeline stage. Uses tafs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tafs_ratio #(
  parameter int SIDE_BITS = tafs_pkg::SIDE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [SIDE_BITS-1:0]        p,
  input  wire logic [SIDE_BITS-1:0]        q,
  input  wire logic [SIDE_BITS-1:0]        m,
  output logic signed [tafs_pkg::FX+1:0]   ratio
);

  localparam int FX  = tafs_pkg::FX;
  localparam int PW  = 2 * SIDE_BITS;
  localparam int SW2 = PW + 1;
  localparam int DW  = PW + 2;
  localparam int RW  = FX + 2;

  // Stage 1: squares and cross product
  logic [PW-1:0] pp_r, qq_r, mm_r, pq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= PW'(p) * PW'(p);
      qq_r <= PW'(q) * PW'(q);
      mm_r <= PW'(m) * PW'(m);
      pq_r <= PW'(p) * PW'(q);
    end
  end

  // Stage 2: magnitude of the numerator, sign, denominator, saturation
  logic [SW2-1:0] sum, msq, diff, den;
  logic           neg, sat, zero;

  always_comb begin
    sum  = SW2'(pp_r) + SW2'(qq_r);
    msq  = SW2'(mm_r);
    neg  = sum < msq;
    diff = neg ? (msq - sum) : (sum - msq);
    den  = {pq_r, 1'b0};
    sat  = diff >= den;
    zero = den == '0;
  end

  logic [DW-1:0]  rem_w  [FX+1];
  logic [FX-1:0]  quo_w  [FX+1];
  logic [SW2-1:0] den_w  [FX+1];
  logic           neg_w  [FX+1];
  logic           sat_w  [FX+1];
  logic           zero_w [FX+1];

  logic [DW-1:0]  rem0_r;
  logic [SW2-1:0] den0_r;
  logic           neg0_r, sat0_r, zero0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r  <= sat ? '0 : DW'(diff);
      den0_r  <= den;
      neg0_r  <= neg;
      sat0_r  <= sat;
      zero0_r <= zero;
    end
  end

  assign rem_w[0]  = rem0_r;
  assign quo_w[0]  = '0;
  assign den_w[0]  = den0_r;
  assign neg_w[0]  = neg0_r;
  assign sat_w[0]  = sat0_r;
  assign zero_w[0] = zero0_r;

  // One quotient bit per stage
  for (genvar i = 0; i < FX; i++) begin : g_div
    logic [DW-1:0]  sh;
    logic           ge;
    logic [DW-1:0]  rem_r;
    logic [FX-1:0]  quo_r;
    logic [SW2-1:0] den_r;
    logic           neg_r, sat_r, zero_r;

    always_comb begin
      sh = {rem_w[i][DW-2:0], 1'b0};
      ge = sh >= DW'(den_w[i]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? (sh - DW'(den_w[i])) : sh;
        quo_r  <= {quo_w[i][FX-2:0], ge};
        den_r  <= den_w[i];
        neg_r  <= neg_w[i];
        sat_r  <= sat_w[i];
        zero_r <= zero_w[i];
      end
    end

    assign rem_w[i+1]  = rem_r;
    assign quo_w[i+1]  = quo_r;
    assign den_w[i+1]  = den_r;
    assign neg_w[i+1]  = neg_r;
    assign sat_w[i+1]  = sat_r;
    assign zero_w[i+1] = zero_r;
  end

  // Rounding half up, then saturation and sign
  logic [DW-1:0]        rsh;
  logic                 up;
  logic [FX:0]          mag;
  logic signed [RW-1:0] ratio_r;

  always_comb begin
    rsh = {rem_w[FX][DW-2:0], 1'b0};
    up  = rsh >= DW'(den_w[FX]);
    priority if (zero_w[FX]) begin
      mag = '0;
    end else if (sat_w[FX]) begin
      mag = (FX+1)'(1) << FX;
    end else begin
      mag = (FX+1)'(quo_w[FX]) + (FX+1)'(up);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ratio_r <= neg_w[FX] ? -$signed(RW'(mag)) : $signed(RW'(mag));
    end
  end

  assign ratio = ratio_r;

endmodule
`default_nettype wire

// ----- src/tafs_acos_step.sv -----
// One binary search step of the arccosine: evaluates cos((mid + 1/2) / 2^F)
// in Q.28 by half angle and Horner, then narrows [lo, hi]. Uses tafs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tafs_acos_step #(
  parameter int ANGLE_FRAC_BITS = tafs_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [ANGLE_FRAC_BITS+1:0]        lo_i,
  input  wire logic [ANGLE_FRAC_BITS+1:0]        hi_i,
  input  wire logic signed [tafs_pkg::FX+1:0]    r_i,
  output logic [ANGLE_FRAC_BITS+1:0]             lo_o,
  output logic [ANGLE_FRAC_BITS+1:0]             hi_o,
  output logic signed [tafs_pkg::FX+1:0]         r_o
);

  localparam int FX    = tafs_pkg::FX;
  localparam int NT    = tafs_pkg::HORNER_TERMS;
  localparam int AW    = ANGLE_FRAC_BITS + 2;
  localparam int RW    = FX + 2;
  localparam int HW    = FX + 1;
  localparam int XW    = FX + 2;
  localparam int SW    = FX + 1;
  localparam int CW    = FX + 3;
  localparam int KW    = AW + 1 + FX;
  localparam int DB    = tafs_pkg::DIV_BITS;
  localparam int RB    = tafs_pkg::RCP_BITS;
  localparam int LAT   = tafs_pkg::STEP_LAT;
  localparam logic [SW-1:0] ONE = SW'(1) << FX;

  typedef struct packed {
    logic [AW-1:0]        lo;
    logic [AW-1:0]        hi;
    logic [AW-1:0]        mid;
    logic signed [RW-1:0] r;
  } ctx_t;

  // Probe point and half angle h = (2 mid + 1) / 2^(F+2)
  logic [AW-1:0] mid;
  logic [KW-1:0] hk;
  ctx_t          ctx_in;

  always_comb begin
    mid    = lo_i + ((hi_i - lo_i) >> 1);
    hk     = (KW'({mid, 1'b1}) << FX) >> (ANGLE_FRAC_BITS + 2);
    ctx_in = '{lo: lo_i, hi: hi_i, mid: mid, r: r_i};
  end

  // Search context travels alongside the cosine pipeline
  ctx_t ctx_r [LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_in;
      for (int i = 1; i < LAT - 1; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
    end
  end

  // h, then h^2
  logic [HW-1:0]   h_r;
  logic [2*HW-1:0] hh;
  logic [XW-1:0]   x2_r;

  assign hh = (2*HW)'(h_r) * (2*HW)'(h_r);

  always_ff @(posedge clk) begin
    if (en) begin
      h_r  <= HW'(hk);
      x2_r <= XW'(hh >> FX);
    end
  end

  logic [SW-1:0] s_w  [NT+1];
  logic [XW-1:0] x2_w [NT+1];

  assign s_w[0]  = ONE;
  assign x2_w[0] = x2_r;

  // Horner: s = 1 - trunc(trunc(s * x2) / (2n(2n-1))), n from 12 down to 1
  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int          N   = NT - j;
    localparam int          D   = 2 * N * (2 * N - 1);
    localparam logic [63:0] RCP = (64'd1 << tafs_pkg::RCP_SHIFT) / D;

    logic [SW+XW-1:0] prod;
    logic [XW+RB-1:0] prod2;
    logic [XW+DB-1:0] prod3, rm;
    logic [XW-1:0]    qv;
    logic [XW:0]      s_nxt;
    logic [XW-1:0]    t_r, tb_r, qe_r;
    logic [XW-1:0]    xa_r, xb_r, xc_r;
    logic [SW-1:0]    s_r;

    always_comb begin
      prod  = (SW+XW)'(s_w[j]) * (SW+XW)'(x2_w[j]);
      prod2 = (XW+RB)'(t_r) * (XW+RB)'(RCP[RB-1:0]);
      prod3 = (XW+DB)'(qe_r) * (XW+DB)'(D);
      rm    = (XW+DB)'(tb_r) - prod3;
      qv    = qe_r + XW'(rm >= (XW+DB)'(D));
      s_nxt = (XW+1)'(ONE) - (XW+1)'(qv);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r  <= XW'(prod >> FX);
        xa_r <= x2_w[j];
        qe_r <= XW'(prod2 >> tafs_pkg::RCP_SHIFT);
        tb_r <= t_r;
        xb_r <= xa_r;
        s_r  <= SW'(s_nxt);
        xc_r <= xb_r;
      end
    end

    assign s_w[j+1]  = s_r;
    assign x2_w[j+1] = xc_r;
  end

  // cos(2h) = 2 cos(h)^2 - 1
  logic [2*SW-1:0]      ss;
  logic [SW-1:0]        sq_r;
  logic signed [CW-1:0] cosv;
  logic                 le;
  ctx_t                 cx;

  always_comb begin
    ss   = (2*SW)'(s_w[NT]) * (2*SW)'(s_w[NT]);
    cx   = ctx_r[LAT-2];
    cosv = $signed({1'b0, sq_r, 1'b0}) - $signed(CW'(ONE));
    le   = CW'(cx.r) <= cosv;
  end

  // Narrow the interval; an empty one stays as it is
  logic [AW-1:0]        lo_r, hi_r, lo_nxt, hi_nxt;
  logic signed [RW-1:0] r_r;

  always_comb begin
    lo_nxt = cx.lo;
    hi_nxt = cx.hi;
    if (cx.lo < cx.hi) begin
      if (le) begin
        lo_nxt = cx.mid + AW'(1);
      end else begin
        hi_nxt = cx.mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= SW'(ss >> FX);
      r_r  <= cx.r;
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign lo_o = lo_r;
  assign hi_o = hi_r;
  assign r_o  = r_r;

endmodule
`default_nettype wire

// ----- src/tafs_lane.sv -----
// One angle lane: cosine ratio unit followed by a chain of search steps.
// Depends on tafs_pkg, tafs_ratio and tafs_acos_step.
`timescale 1ns / 1ps
`default_nettype none
module tafs_lane #(
  parameter int SIDE_BITS       = tafs_pkg::SIDE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = tafs_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [SIDE_BITS-1:0]         p,
  input  wire logic [SIDE_BITS-1:0]         q,
  input  wire logic [SIDE_BITS-1:0]         m,
  output logic [ANGLE_FRAC_BITS+1:0]        angle
);

  localparam int AW    = ANGLE_FRAC_BITS + 2;
  localparam int RW    = tafs_pkg::FX + 2;
  localparam int STEPS = tafs_pkg::search_steps(ANGLE_FRAC_BITS);
  localparam logic [AW-1:0] YMAX = AW'(tafs_pkg::ymax_of(ANGLE_FRAC_BITS));

  logic signed [RW-1:0] ratio;

  tafs_ratio #(
    .SIDE_BITS (SIDE_BITS)
  ) u_ratio (
    .clk   (clk),
    .en    (en),
    .p     (p),
    .q     (q),
    .m     (m),
    .ratio (ratio)
  );

  logic [AW-1:0]        lo_w [STEPS+1];
  logic [AW-1:0]        hi_w [STEPS+1];
  logic signed [RW-1:0] r_w  [STEPS+1];

  assign lo_w[0] = '0;
  assign hi_w[0] = YMAX;
  assign r_w[0]  = ratio;

  // Search chain: each step halves the interval of candidate angles
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    tafs_acos_step #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_step (
      .clk  (clk),
      .en   (en),
      .lo_i (lo_w[k]),
      .hi_i (hi_w[k]),
      .r_i  (r_w[k]),
      .lo_o (lo_w[k+1]),
      .hi_o (hi_w[k+1]),
      .r_o  (r_w[k+1])
    );
  end

  assign angle = lo_w[STEPS];

endmodule
`default_nettype wire

// ----- src/triangle_angles_from_sides.sv -----
// Top level of the triangle angle block: stream ports, triangle check,
// three angle lanes and the merging output register. Uses tafs_pkg, tafs_lane.
`timescale 1ns / 1ps
`default_nettype none
// Takes three side lengths per transfer and returns forms_triangle and the
// three angles in unsigned Q2.ANGLE_FRAC_BITS radians (zeros when the sides
// fail the strict triangle inequality). Fully pipelined: one triangle is
// accepted every cycle unless the output stalls. From input transfer to
// result, data passes the cosine ratio divider (one quotient bit a stage),
// then the 16 binary search steps of the arccosine at the defaults, each
// step evaluating one cosine threshold by a 12-term Horner pipeline, and
// then the output register. The whole pipeline holds while a result waits
// on out_tready.
module triangle_angles_from_sides #(
  parameter int SIDE_BITS       = tafs_pkg::SIDE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = tafs_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // side_a, side_b, side_c from bit 0 up
  input  wire logic [tafs_pkg::bytes_up(3*SIDE_BITS)-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // forms_triangle, angle_a, angle_b, angle_c from bit 0 up
  output logic [tafs_pkg::bytes_up(1+3*(ANGLE_FRAC_BITS+2))-1:0] out_tdata
);

  localparam int SB   = SIDE_BITS;
  localparam int AW   = ANGLE_FRAC_BITS + 2;
  localparam int OW   = tafs_pkg::bytes_up(1 + 3 * AW);
  localparam int LAT  = tafs_pkg::RATIO_LAT
                        + tafs_pkg::search_steps(ANGLE_FRAC_BITS) * tafs_pkg::STEP_LAT;
  localparam logic [AW-1:0] YMAX = AW'(tafs_pkg::ymax_of(ANGLE_FRAC_BITS));

  // Pipeline advances unless a result is held
  logic adv, take;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign take      = in_tvalid && adv;

  logic [SB-1:0] side_a, side_b, side_c;
  logic          ok;

  always_comb begin
    side_a = in_tdata[SB-1:0];
    side_b = in_tdata[2*SB-1:SB];
    side_c = in_tdata[3*SB-1:2*SB];
    ok     = ((SB+1)'(side_a) + (SB+1)'(side_b) > (SB+1)'(side_c))
          && ((SB+1)'(side_b) + (SB+1)'(side_c) > (SB+1)'(side_a))
          && ((SB+1)'(side_a) + (SB+1)'(side_c) > (SB+1)'(side_b));
  end

  // Angle lanes: A between b and c, B between a and c, C between a and b
  logic [AW-1:0] ang_a, ang_b, ang_c;

  tafs_lane #(.SIDE_BITS(SB), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_a (
    .clk (clk), .en (adv), .p (side_b), .q (side_c), .m (side_a), .angle (ang_a)
  );

  tafs_lane #(.SIDE_BITS(SB), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_b (
    .clk (clk), .en (adv), .p (side_a), .q (side_c), .m (side_b), .angle (ang_b)
  );

  tafs_lane #(.SIDE_BITS(SB), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_c (
    .clk (clk), .en (adv), .p (side_a), .q (side_b), .m (side_c), .angle (ang_c)
  );

  // Valid and triangle flag ride along with the lanes
  logic v_r  [LAT];
  logic ok_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= take;
      for (int i = 1; i < LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r[0] <= ok;
      for (int i = 1; i < LAT; i++) begin
        ok_r[i] <= ok_r[i-1];
      end
    end
  end

  // Merge stage and output register
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [OW-1:0] out_data_r, out_data_nxt;
  logic [AW-1:0] oa, ob, oc;

  always_comb begin
    oa             = ok_r[LAT-1] ? ang_a : '0;
    ob             = ok_r[LAT-1] ? ang_b : '0;
    oc             = ok_r[LAT-1] ? ang_c : '0;
    out_tvalid_nxt = v_r[LAT-1];
    out_data_nxt   = OW'({oc, ob, oa, ok_r[LAT-1]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  logic          q_ok;
  logic [AW-1:0] q_a, q_b, q_c;
  assign q_ok = out_data_r[0];
  assign q_a  = out_data_r[AW:1];
  assign q_b  = out_data_r[2*AW:AW+1];
  assign q_c  = out_data_r[3*AW:2*AW+1];

  // Sides that are no triangle give all-zero angles
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !q_ok |-> (q_a == '0) && (q_b == '0) && (q_c == '0))
    else $error("angles nonzero for sides that form no triangle");

  // No angle exceeds pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (q_a <= YMAX) && (q_b <= YMAX) && (q_c <= YMAX))
    else $error("angle code above pi");

  // The largest angle of a triangle is at least pi/3, so not all are zero
  a_triangle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && q_ok |-> (q_a != '0) || (q_b != '0) || (q_c != '0))
    else $error("triangle reported with all angles zero");

  // Nothing leaves the pipeline on the first cycle out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid_r)
    else $error("result presented right after reset");
`endif

endmodule
`default_nettype wire
